### rtl/htfl_pkg.sv
// Shared codes, widths and control types for the handle table.
package htfl_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned WordW   = 64;
  localparam int unsigned HandleW = 8;
  localparam int unsigned StatW   = 2;

  localparam logic [FuncW-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FuncW-1:0] FN_LOOKUP  = 2'd1;
  localparam logic [FuncW-1:0] FN_RELEASE = 2'd2;

  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_FULL = 2'd1;
  localparam logic [StatW-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic take;
    logic finish;
  } cmd_t;

endpackage

### rtl/htfl_if.sv
// Request and response channel interfaces of the handle table.
interface htfl_req_if;
  logic                          valid;
  logic                          ready;
  logic [htfl_pkg::FuncW-1:0]    func;
  logic [htfl_pkg::WordW-1:0]    data_word;
  logic [htfl_pkg::HandleW-1:0]  handle;

  modport source (output valid, output func, output data_word, output handle, input ready);
  modport sink   (input valid, input func, input data_word, input handle, output ready);
endinterface

interface htfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [htfl_pkg::HandleW-1:0]  handle_out;
  logic [htfl_pkg::WordW-1:0]    word_out;
  logic [htfl_pkg::StatW-1:0]    status;

  modport source (output valid, output handle_out, output word_out, output status, input ready);
  modport sink   (input valid, input handle_out, input word_out, input status, output ready);
endinterface

### rtl/handle_table_free_list.sv
// Handle table with a last-in first-out free list of released slots.
// A release, an allocate of a never-used slot, any full or out-of-range
// answer and the unused function code load the response register; a look
// up and an allocate that pops the free list wait in S_READ for the
// registered read of the word and link memories. One request is in work
// at a time; a new word is taken as soon as the response register is empty
// or being taken in the same cycle. Slots above 255 (DEPTH over 256) show
// only their low eight bits on handle_out. No clearing pass: never-written
// entries are only ever read by a look up of a slot never allocated.
module handle_table_free_list #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  htfl_req_if.sink    in_i,
  htfl_rsp_if.source  out_o
);

  htfl_pkg::cmd_t cmd;
  logic           needs_read;
  logic           in_ready;
  logic           out_valid;

  htfl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .needs_read_i (needs_read),
    .out_ready_i  (out_o.ready),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .cmd_o        (cmd)
  );

  htfl_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (in_i.func),
    .data_word_i  (in_i.data_word),
    .handle_i     (in_i.handle),
    .needs_read_o (needs_read),
    .handle_out_o (out_o.handle_out),
    .word_out_o   (out_o.word_out),
    .status_o     (out_o.status)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

### rtl/htfl_ctrl.sv
// Controller: request intake, read wait state and response valid.
module htfl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             needs_read_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output htfl_pkg::cmd_t   cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   take;
  logic   finish;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign take        = in_valid_i && in_ready_o;
  assign finish      = (state_q == S_READ);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = '{take: take, finish: finish};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (take && needs_read_i) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if ((take && !needs_read_i) || finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/htfl_dpath.sv
// Datapath: free list pointers, link and word memories, response register.
module htfl_dpath #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  htfl_pkg::cmd_t                cmd_i,
  input  logic [htfl_pkg::FuncW-1:0]    func_i,
  input  logic [htfl_pkg::WordW-1:0]    data_word_i,
  input  logic [htfl_pkg::HandleW-1:0]  handle_i,
  output logic                          needs_read_o,
  output logic [htfl_pkg::HandleW-1:0]  handle_out_o,
  output logic [htfl_pkg::WordW-1:0]    word_out_o,
  output logic [htfl_pkg::StatW-1:0]    status_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [htfl_pkg::WordW-1:0] word_mem [DEPTH];
  logic [CW-1:0]              link_mem [DEPTH];

  logic [CW-1:0]              free_top_q, free_top_d;
  logic [CW-1:0]              used_count_q, used_count_d;
  logic                       pend_alloc_q;
  logic [IW-1:0]              pend_slot_q;
  logic [htfl_pkg::WordW-1:0] pend_data_q;
  logic [htfl_pkg::WordW-1:0] word_rd_q;
  logic [CW-1:0]              link_rd_q;

  logic [htfl_pkg::HandleW-1:0] handle_out_q, handle_out_d;
  logic [htfl_pkg::WordW-1:0]   word_out_q, word_out_d;
  logic [htfl_pkg::StatW-1:0]   status_q, status_d;

  logic                       list_empty;
  logic                       table_full;
  logic                       handle_bad;
  logic [IW-1:0]              top_slot;
  logic [IW-1:0]              fresh_slot;
  logic [IW-1:0]              h_slot;
  logic                       word_we;
  logic [IW-1:0]              word_wa;
  logic [htfl_pkg::WordW-1:0] word_wd;
  logic                       link_we;

  assign list_empty = (free_top_q == '0);
  assign table_full = (used_count_q == CW'(DEPTH));
  assign handle_bad = (32'(handle_i) >= 32'(DEPTH));
  assign top_slot   = IW'(free_top_q - CW'(1));
  assign fresh_slot = IW'(used_count_q);
  assign h_slot     = IW'(handle_i);

  assign needs_read_o = ((func_i == htfl_pkg::FN_ALLOC) && !list_empty) ||
                        ((func_i == htfl_pkg::FN_LOOKUP) && !handle_bad);

  assign word_we = (cmd_i.take && (func_i == htfl_pkg::FN_ALLOC) && list_empty && !table_full) ||
                   (cmd_i.finish && pend_alloc_q);
  assign word_wa = cmd_i.finish ? pend_slot_q : fresh_slot;
  assign word_wd = cmd_i.finish ? pend_data_q : data_word_i;
  assign link_we = cmd_i.take && (func_i == htfl_pkg::FN_RELEASE) && !handle_bad;

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_wa] <= word_wd;
    end
    word_rd_q <= word_mem[h_slot];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[h_slot] <= free_top_q;
    end
    link_rd_q <= link_mem[top_slot];
  end

  always_comb begin
    free_top_d   = free_top_q;
    used_count_d = used_count_q;
    if (cmd_i.take) begin
      case (func_i)
        htfl_pkg::FN_ALLOC: begin
          if (list_empty && !table_full) begin
            used_count_d = used_count_q + CW'(1);
          end
        end
        htfl_pkg::FN_RELEASE: begin
          if (!handle_bad) begin
            free_top_d = CW'(h_slot) + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.finish && pend_alloc_q) begin
      free_top_d = link_rd_q;
    end
  end

  always_comb begin
    handle_out_d = handle_out_q;
    word_out_d   = word_out_q;
    status_d     = status_q;
    if (cmd_i.take) begin
      handle_out_d = '0;
      word_out_d   = '0;
      status_d     = htfl_pkg::ST_OK;
      case (func_i) inside
        htfl_pkg::FN_ALLOC: begin
          if (list_empty && !table_full) begin
            handle_out_d = htfl_pkg::HandleW'(fresh_slot);
          end else if (list_empty) begin
            status_d = htfl_pkg::ST_FULL;
          end
        end
        htfl_pkg::FN_LOOKUP, htfl_pkg::FN_RELEASE: begin
          if (handle_bad) begin
            status_d = htfl_pkg::ST_BAD;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.finish) begin
      status_d = htfl_pkg::ST_OK;
      if (pend_alloc_q) begin
        handle_out_d = htfl_pkg::HandleW'(pend_slot_q);
        word_out_d   = '0;
      end else begin
        handle_out_d = '0;
        word_out_d   = word_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q   <= '0;
      used_count_q <= '0;
    end else begin
      free_top_q   <= free_top_d;
      used_count_q <= used_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pend_alloc_q <= (func_i == htfl_pkg::FN_ALLOC);
      pend_slot_q  <= top_slot;
      pend_data_q  <= data_word_i;
    end
    handle_out_q <= handle_out_d;
    word_out_q   <= word_out_d;
    status_q     <= status_d;
  end

  assign handle_out_o = handle_out_q;
  assign word_out_o   = word_out_q;
  assign status_o     = status_q;

endmodule

### rtl/htfl_checker.sv
// Port-level checks of the handle table, bound to the top level.
module htfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [htfl_pkg::FuncW-1:0]    in_func_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [htfl_pkg::HandleW-1:0]  out_handle_i,
  input logic [htfl_pkg::WordW-1:0]    out_word_i,
  input logic [htfl_pkg::StatW-1:0]    out_status_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i) &&
    $stable(out_handle_i) && $stable(out_status_i))
    else $error("response word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != htfl_pkg::ST_OK) |->
    (out_handle_i == '0) && (out_word_i == '0))
    else $error("error response carries nonzero payload");

  a_release_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func_i == htfl_pkg::FN_RELEASE) |=>
    out_valid_i && (out_status_i != htfl_pkg::ST_FULL))
    else $error("release answer missing or wrong");

  a_lookup_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func_i == htfl_pkg::FN_LOOKUP) |=> !in_ready_i)
    else $error("intake open during lookup read");

endmodule

bind handle_table_free_list htfl_checker u_htfl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_handle_i (out_o.handle_out),
  .out_word_i   (out_o.word_out),
  .out_status_i (out_o.status)
);

### dv/handle_table_free_list_tb.sv
// Self-checking testbench for the handle table: a scoreboard predicts answers from the requests.
`timescale 1ns / 1ps

module handle_table_free_list_tb;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned ReportLimit = 10;
  localparam logic [htfl_pkg::FuncW-1:0] FnSpare = 2'd3;

  typedef struct packed {
    logic [htfl_pkg::HandleW-1:0] handle;
    logic [htfl_pkg::WordW-1:0]   word;
    logic [htfl_pkg::StatW-1:0]   status;
  } answer_t;

  class slot_ledger;
    int unsigned                free_head;
    int unsigned                fresh_count;
    int unsigned                next_link[TableDepth];
    logic [htfl_pkg::WordW-1:0] stored_word[TableDepth];
    answer_t                    pending_answers[$];
    int unsigned                error_count;

    function new();
      free_head = 0;
      fresh_count = 0;
      error_count = 0;
      foreach (next_link[i]) next_link[i] = 0;
      foreach (stored_word[i]) stored_word[i] = '0;
    endfunction

    function answer_t note_request(input logic [htfl_pkg::FuncW-1:0] func,
                                   input logic [htfl_pkg::WordW-1:0] data,
                                   input logic [htfl_pkg::HandleW-1:0] h);
      answer_t     a;
      int unsigned slot;
      a = '0;
      a.status = htfl_pkg::ST_OK;
      slot = 0;
      case (func)
        htfl_pkg::FN_ALLOC: begin
          if (free_head != 0) begin
            slot = free_head - 1;
            free_head = next_link[slot];
          end else if (fresh_count < TableDepth) begin
            slot = fresh_count;
            fresh_count++;
          end else begin
            a.status = htfl_pkg::ST_FULL;
          end
          if (a.status == htfl_pkg::ST_OK) begin
            stored_word[slot] = data;
            a.handle = htfl_pkg::HandleW'(slot);
          end
        end
        htfl_pkg::FN_LOOKUP: begin
          if (int'(h) >= TableDepth) a.status = htfl_pkg::ST_BAD;
          else a.word = stored_word[h];
        end
        htfl_pkg::FN_RELEASE: begin
          if (int'(h) >= TableDepth) begin
            a.status = htfl_pkg::ST_BAD;
          end else begin
            next_link[h] = free_head;
            free_head = int'(h) + 1;
          end
        end
        default: ;
      endcase
      pending_answers.push_back(a);
      return a;
    endfunction

    function void check_response(input answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("unexpected answer: handle %0d word %h status %0d",
                   got.handle, got.word, got.status);
        return;
      end
      want = pending_answers.pop_front();
      if (got.handle !== want.handle || got.word !== want.word || got.status !== want.status)
          begin
        error_count++;
        if (error_count <= ReportLimit)
          $display({"mismatch: expected handle %0d word %h status %0d, ",
                    "got handle %0d word %h status %0d"},
                   want.handle, want.word, want.status, got.handle, got.word, got.status);
      end
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  htfl_req_if req_if ();
  htfl_rsp_if rsp_if ();

  handle_table_free_list #(
    .DEPTH(TableDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  slot_ledger ledger = new();

  bit          slot_live[TableDepth];
  bit          slot_written[TableDepth];
  int unsigned src_idle_pct;
  int unsigned rsp_idle_pct;
  int unsigned hold_cycles;
  int unsigned alloc_pct;
  int unsigned lookup_pct;
  int unsigned noise_pct;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready)
        ledger.check_response({rsp_if.handle_out, rsp_if.word_out, rsp_if.status});
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_slot(input bit want_live);
    int start;
    int idx;
    start = $urandom_range(TableDepth - 1);
    for (int i = 0; i < TableDepth; i++) begin
      idx = (start + i) % TableDepth;
      if (want_live ? slot_live[idx] : slot_written[idx]) return idx;
    end
    return -1;
  endfunction

  task automatic send_word(input logic [htfl_pkg::FuncW-1:0] func,
                           input logic [htfl_pkg::WordW-1:0] data,
                           input logic [htfl_pkg::HandleW-1:0] h);
    answer_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= func;
    req_if.data_word <= data;
    req_if.handle    <= h;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = ledger.note_request(func, data, h);
    if (predicted.status == htfl_pkg::ST_OK) begin
      if (func == htfl_pkg::FN_ALLOC) begin
        slot_live[predicted.handle] = 1'b1;
        slot_written[predicted.handle] = 1'b1;
      end else if (func == htfl_pkg::FN_RELEASE) begin
        slot_live[h] = 1'b0;
      end
    end
  endtask

  task automatic send_random(input bit noisy);
    logic [htfl_pkg::FuncW-1:0]   func;
    logic [htfl_pkg::WordW-1:0]   data;
    logic [htfl_pkg::HandleW-1:0] h;
    int                           roll;
    int                           pick;
    roll = $urandom_range(99);
    data = {$urandom, $urandom};
    h = htfl_pkg::HandleW'($urandom_range(255));
    func = htfl_pkg::FN_ALLOC;
    if (roll >= 95) begin
      func = FnSpare;
    end else if (roll >= alloc_pct + lookup_pct) begin
      pick = noisy ? int'(h) : pick_slot(1'b1);
      if (pick >= 0) begin
        func = htfl_pkg::FN_RELEASE;
        h = htfl_pkg::HandleW'(pick);
      end
    end else if (roll >= alloc_pct) begin
      pick = pick_slot(1'b0);
      if (pick >= 0) begin
        func = htfl_pkg::FN_LOOKUP;
        h = htfl_pkg::HandleW'(pick);
      end
    end
    send_word(func, data, h);
  endtask

  task automatic drain_answers();
    req_if.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_random($urandom_range(99) < noise_pct);
    drain_answers();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.func      <= htfl_pkg::FN_ALLOC;
    req_if.data_word <= '0;
    req_if.handle    <= '0;
    hold_cycles = 0;
    src_idle_pct = 20;
    rsp_idle_pct = 62;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(htfl_pkg::FN_ALLOC, 64'h0, 8'h00);
    send_word(htfl_pkg::FN_ALLOC, '1, 8'hFF);
    send_word(htfl_pkg::FN_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
    send_word(htfl_pkg::FN_ALLOC, 64'h5555_5555_5555_5555, 8'hAA);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'd0);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'd1);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'd2);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'd3);
    send_word(htfl_pkg::FN_RELEASE, '0, 8'd1);
    send_word(htfl_pkg::FN_RELEASE, '0, 8'd2);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'd2);
    send_word(htfl_pkg::FN_ALLOC, 64'h0123_4567_89AB_CDEF, 8'h00);
    send_word(htfl_pkg::FN_ALLOC, 64'hFEDC_BA98_7654_3210, 8'h00);
    send_word(htfl_pkg::FN_ALLOC, 64'h8000_0000_0000_0001, 8'h00);
    send_word(htfl_pkg::FN_RELEASE, '1, 8'hFF);
    send_word(htfl_pkg::FN_ALLOC, 64'h7FFF_FFFF_FFFF_FFFE, 8'h00);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'hFF);
    send_word(FnSpare, '1, 8'hFF);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'd1);
    send_word(htfl_pkg::FN_RELEASE, '0, 8'd0);
    send_word(htfl_pkg::FN_ALLOC, 64'hC3C3_C3C3_3C3C_3C3C, 8'h00);
    send_word(htfl_pkg::FN_LOOKUP, '0, 8'd0);
    drain_answers();

    alloc_pct = 65;
    lookup_pct = 20;
    noise_pct = 0;
    run_phase(600);

    src_idle_pct = 62;
    rsp_idle_pct = 20;
    alloc_pct = 35;
    lookup_pct = 35;
    noise_pct = 15;
    hold_cycles = 80;
    run_phase(420);

    src_idle_pct = 0;
    rsp_idle_pct = 0;
    alloc_pct = 45;
    lookup_pct = 30;
    run_phase(420);

    repeat (10) @(posedge clk_i);
    if (ledger.error_count == 0 && ledger.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/htfl_pkg.sv
rtl/htfl_if.sv
rtl/htfl_ctrl.sv
rtl/htfl_dpath.sv
rtl/handle_table_free_list.sv
rtl/htfl_checker.sv
dv/handle_table_free_list_tb.sv
